[src/cmt_pkg.sv]
// Shared types, codes and constants for the compare match timer.
package cmt_pkg;

   localparam int DEF_CHANNELS    = 4;
   localparam int DEF_COUNT_WIDTH = 16;
   localparam int DATA_WIDTH      = 16;
   localparam int PRESCALE_WIDTH  = 9;
   localparam int IE_BIT          = 6;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_CONTROL = 2'd0,
      REG_COMPARE = 2'd1,
      REG_COUNTER = 2'd2,
      REG_START   = 2'd3
   } reg_type;

   // per-channel strobes from the decode
   typedef struct packed {
      logic                  tick;
      logic                  wr_control;
      logic                  wr_compare;
      logic                  wr_counter;
      logic                  wr_start;
      logic                  start_on;
      logic [DATA_WIDTH-1:0] data;
   } ctl_type;

   // per-channel status back to the read mux
   typedef struct packed {
      logic       running;
      logic       irq_enable;
      logic [1:0] clock_select;
      logic       irq;
   } sts_type;

   // terminal prescaler count: divide by 8, 32, 128 or 512
   function automatic logic [PRESCALE_WIDTH-1:0] prescale_last(input logic [1:0] sel);
      logic [PRESCALE_WIDTH-1:0] last;
      case (sel)
         2'd0:    last = 9'd7;
         2'd1:    last = 9'd31;
         2'd2:    last = 9'd127;
         default: last = 9'd511;
      endcase
      return last;
   endfunction

endpackage

[src/cmt_channel.sv]
// One timer channel: prescaler, counter, compare and control state.
module cmt_channel #(
   parameter int COUNT_WIDTH = cmt_pkg::DEF_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmt_pkg::ctl_type       ctl,
   output cmt_pkg::sts_type       sts,
   output logic [COUNT_WIDTH-1:0] counter,
   output logic [COUNT_WIDTH-1:0] compare
);

   logic [COUNT_WIDTH-1:0]             cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0]             cmp_ff, cmp_in;
   logic [cmt_pkg::PRESCALE_WIDTH-1:0] pre_ff, pre_in;
   logic [1:0]                         sel_ff, sel_in;
   logic                               ie_ff, ie_in;
   logic                               run_ff, run_in;
   logic                               irq;

   always_comb begin
      cnt_in = cnt_ff;
      cmp_in = cmp_ff;
      pre_in = pre_ff;
      sel_in = sel_ff;
      ie_in  = ie_ff;
      run_in = run_ff;
      irq    = 1'b0;
      if (ctl.wr_control) begin
         sel_in = ctl.data[1:0];
         ie_in  = ctl.data[cmt_pkg::IE_BIT];
      end
      if (ctl.wr_compare) begin
         cmp_in = COUNT_WIDTH'(ctl.data);
      end
      if (ctl.wr_counter) begin
         cnt_in = COUNT_WIDTH'(ctl.data);
      end
      if (ctl.wr_start) begin
         if (ctl.start_on && !run_ff) begin
            pre_in = '0;
         end
         run_in = ctl.start_on;
      end
      if (ctl.tick && run_ff) begin
         if (pre_ff >= cmt_pkg::prescale_last(sel_ff)) begin
            pre_in = '0;
            if (cnt_ff == cmp_ff) begin
               cnt_in = '0;
               irq    = ie_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end else begin
            pre_in = pre_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         cmp_ff <= '1;
         pre_ff <= '0;
         sel_ff <= 2'd0;
         ie_ff  <= 1'b0;
         run_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         cmp_ff <= cmp_in;
         pre_ff <= pre_in;
         sel_ff <= sel_in;
         ie_ff  <= ie_in;
         run_ff <= run_in;
      end
   end

   assign sts.running      = run_ff;
   assign sts.irq_enable   = ie_ff;
   assign sts.clock_select = sel_ff;
   assign sts.irq          = irq;
   assign counter          = cnt_ff;
   assign compare          = cmp_ff;

endmodule

[src/compare_match_timer_core.sv]
// Compare match timer top level: word registers, decode, read mux and channels.
// Path: a request word is held in the input register, and its result word in the result register.
// Throughput: one word per cycle while rsp_tready stays high; all work is one pass between the input and
// result registers, and the input register holds one word while a result waits.
// Reset: synchronous, active high; counters, prescalers, control and start clear,
// compare values go to all ones and both word registers empty.
module compare_match_timer_core #(
   parameter int CHANNELS    = cmt_pkg::DEF_CHANNELS,
   parameter int COUNT_WIDTH = cmt_pkg::DEF_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // channel[1:0], reg_select[3:2], write_data[19:4]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_data[15:0], match_irq[19:16]
);

   localparam int DW = cmt_pkg::DATA_WIDTH;

   logic          in_valid_ff;
   logic [1:0]    in_op_ff;
   logic [1:0]    in_ch_ff;
   logic [1:0]    in_sel_ff;
   logic [DW-1:0] in_data_ff;

   logic          out_valid_ff;
   logic [DW-1:0] out_read_ff, out_read_in;
   logic [3:0]    out_irq_ff, out_irq_in;

   logic          advance;
   logic          ch_present;
   logic          wr;
   logic [3:0]    run4;
   logic [3:0]    irq4;
   logic [DW-1:0] rd;

   cmt_pkg::ctl_type       ctl [CHANNELS];
   cmt_pkg::sts_type       sts [CHANNELS];
   logic [COUNT_WIDTH-1:0] cnt [CHANNELS];
   logic [COUNT_WIDTH-1:0] cmp [CHANNELS];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign ch_present = {1'b0, in_ch_ff} < 3'(CHANNELS);
   assign wr         = advance && (in_op_ff == cmt_pkg::OP_WRITE) && ch_present;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
      localparam logic [1:0] CH = 2'(c);
      always_comb begin
         ctl[c].tick       = advance && (in_op_ff == cmt_pkg::OP_TICK);
         ctl[c].wr_control = wr && (in_sel_ff == cmt_pkg::REG_CONTROL) && (in_ch_ff == CH);
         ctl[c].wr_compare = wr && (in_sel_ff == cmt_pkg::REG_COMPARE) && (in_ch_ff == CH);
         ctl[c].wr_counter = wr && (in_sel_ff == cmt_pkg::REG_COUNTER) && (in_ch_ff == CH);
         ctl[c].wr_start   = wr && (in_sel_ff == cmt_pkg::REG_START) && (in_ch_ff[1] == CH[1]);
         ctl[c].start_on   = in_data_ff[CH[0]];
         ctl[c].data       = in_data_ff;
      end

      cmt_channel #(
         .COUNT_WIDTH(COUNT_WIDTH)
      ) u_channel (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[c]),
         .sts    (sts[c]),
         .counter(cnt[c]),
         .compare(cmp[c])
      );
   end

   always_comb begin
      run4 = '0;
      irq4 = '0;
      rd   = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         run4[c] = sts[c].running;
         irq4[c] = sts[c].irq;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         if (in_ch_ff == 2'(c)) begin
            case (in_sel_ff)
               cmt_pkg::REG_CONTROL: begin
                  rd = '0;
                  rd[1:0] = sts[c].clock_select;
                  rd[cmt_pkg::IE_BIT] = sts[c].irq_enable;
               end
               cmt_pkg::REG_COMPARE: rd = DW'(cmp[c]);
               cmt_pkg::REG_COUNTER: rd = DW'(cnt[c]);
               default:              rd = {14'd0, in_ch_ff[1] ? run4[3:2] : run4[1:0]};
            endcase
         end
      end
      out_read_in = (in_op_ff == cmt_pkg::OP_READ && ch_present) ? rd : '0;
      out_irq_in  = (in_op_ff == cmt_pkg::OP_TICK) ? irq4 : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_ch_ff   <= req_tdata[1:0];
         in_sel_ff  <= req_tdata[3:2];
         in_data_ff <= req_tdata[19:4];
      end
      if (advance) begin
         out_read_ff <= out_read_in;
         out_irq_ff  <= out_irq_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_irq_ff, out_read_ff};

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !((|out_read_ff) && (|out_irq_ff)))
      else $error("read data and match bits in one word");

   a_absent_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_irq_ff >> CHANNELS) == 4'd0))
      else $error("match bit from an absent channel");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("result register empty after an advance");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held request word lost");

endmodule

[tb/testbench.sv]
// Self-checking stream testbench for the compare match timer core.
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_WORDS = 400;
   localparam int CALM_TAIL = 60;

   typedef struct packed {
      logic [1:0]       op;
      logic [1:0]       channel;
      cmt_pkg::reg_type sel;
      logic [15:0]      wdata;
   } req_word_type;

   typedef struct packed {
      logic [15:0] rdata;
      logic [3:0]  irq;
   } timer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   req_word_type     pending_words[$];
   timer_result_type due_results[$];

   // predicted timer state
   bit [15:0] count_q[4];
   bit [15:0] compare_q[4];
   bit [1:0]  divsel[4];
   bit        irq_en[4];
   bit        run[4];
   bit [8:0]  prescale[4];

   int send_gap = 0;
   int recv_hold = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int n_ticks = 0;
   int n_reads = 0;
   int n_writes = 0;
   int n_irq_words = 0;
   bit calm;

   compare_match_timer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign calm = pending_words.size() < CALM_TAIL;

   function automatic timer_result_type cmt_advance(req_word_type w);
      timer_result_type r;
      int base;
      int last;
      int c;
      r = '0;
      base = w.channel & 2'b10;
      if (w.op == cmt_pkg::OP_TICK) begin
         for (c = 0; c < 4; c++) begin
            if (run[c]) begin
               last = (8 << (2 * divsel[c])) - 1;
               if (prescale[c] >= last) begin
                  prescale[c] = '0;
                  if (count_q[c] == compare_q[c]) begin
                     count_q[c] = '0;
                     if (irq_en[c])
                        r.irq[c] = 1'b1;
                  end else begin
                     count_q[c] = count_q[c] + 16'd1;
                  end
               end else begin
                  prescale[c] = prescale[c] + 9'd1;
               end
            end
         end
      end else if (w.op == cmt_pkg::OP_READ) begin
         case (w.sel)
            cmt_pkg::REG_CONTROL:
               r.rdata = {9'd0, irq_en[w.channel], 4'd0, divsel[w.channel]};
            cmt_pkg::REG_COMPARE: r.rdata = compare_q[w.channel];
            cmt_pkg::REG_COUNTER: r.rdata = count_q[w.channel];
            cmt_pkg::REG_START:   r.rdata = {14'd0, run[base + 1], run[base]};
            default:              r.rdata = '0;
         endcase
      end else if (w.op == cmt_pkg::OP_WRITE) begin
         case (w.sel)
            cmt_pkg::REG_CONTROL: begin
               divsel[w.channel] = w.wdata[1:0];
               irq_en[w.channel] = w.wdata[cmt_pkg::IE_BIT];
            end
            cmt_pkg::REG_COMPARE: compare_q[w.channel] = w.wdata;
            cmt_pkg::REG_COUNTER: count_q[w.channel] = w.wdata;
            cmt_pkg::REG_START: begin
               for (c = 0; c < 2; c++) begin
                  if (w.wdata[c] && !run[base + c])
                     prescale[base + c] = '0;
                  run[base + c] = w.wdata[c];
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic queue_word(logic [1:0] op, logic [1:0] channel, cmt_pkg::reg_type sel,
                             logic [15:0] wdata);
      req_word_type w;
      w.op = op;
      w.channel = channel;
      w.sel = sel;
      w.wdata = wdata;
      pending_words.push_back(w);
   endtask

   function automatic logic [15:0] small_or_wide();
      if ($urandom_range(0, 5) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 6));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(cmt_advance(pending_words[0]));
            case (pending_words[0].op)
               cmt_pkg::OP_TICK:  n_ticks++;
               cmt_pkg::OP_READ:  n_reads++;
               cmt_pkg::OP_WRITE: n_writes++;
               default: ;
            endcase
            pending_words.pop_front();
            if (!calm && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 11);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, pending_words[0].wdata, pending_words[0].sel,
                           pending_words[0].channel};
            req_tuser  <= pending_words[0].op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word %h", $realtime, rsp_tdata);
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[19:16] != 4'd0)
                  n_irq_words++;
               if (rsp_tdata[15:0] !== want.rdata || rsp_tdata[19:16] !== want.irq) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: read_data exp %h got %h, match_irq exp %h got %h",
                              $realtime, want.rdata, rsp_tdata[15:0], want.irq,
                              rsp_tdata[19:16]);
               end
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_hold = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on words moving
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no word moving", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int r;
      int ch;
      int total;
      for (int c = 0; c < 4; c++) begin
         count_q[c] = '0;
         compare_q[c] = 16'hFFFF;
         divsel[c] = '0;
         irq_en[c] = 1'b0;
         run[c] = 1'b0;
         prescale[c] = '0;
      end

      // reset values, unused op, control extremes
      queue_word(cmt_pkg::OP_READ, 2'd0, cmt_pkg::REG_CONTROL, 16'h0000);
      queue_word(cmt_pkg::OP_READ, 2'd1, cmt_pkg::REG_COMPARE, 16'hFFFF);
      queue_word(cmt_pkg::OP_READ, 2'd2, cmt_pkg::REG_COUNTER, 16'h0000);
      queue_word(cmt_pkg::OP_READ, 2'd3, cmt_pkg::REG_START, 16'hFFFF);
      queue_word(OP_UNUSED, 2'd3, cmt_pkg::REG_START, 16'hFFFF);
      queue_word(cmt_pkg::OP_WRITE, 2'd0, cmt_pkg::REG_CONTROL, 16'hFFFF);
      queue_word(cmt_pkg::OP_READ, 2'd0, cmt_pkg::REG_CONTROL, 16'h0000);
      queue_word(cmt_pkg::OP_WRITE, 2'd0, cmt_pkg::REG_CONTROL, 16'h0040);
      // counter above compare wraps through all ones without a match
      queue_word(cmt_pkg::OP_WRITE, 2'd0, cmt_pkg::REG_COMPARE, 16'h0000);
      queue_word(cmt_pkg::OP_WRITE, 2'd0, cmt_pkg::REG_COUNTER, 16'hFFFF);
      queue_word(cmt_pkg::OP_WRITE, 2'd0, cmt_pkg::REG_START, 16'hFFFF);
      queue_word(cmt_pkg::OP_READ, 2'd1, cmt_pkg::REG_START, 16'h0000);
      // restart of a running pair leaves the prescaler alone
      queue_word(cmt_pkg::OP_WRITE, 2'd1, cmt_pkg::REG_START, 16'h0003);
      repeat (8) queue_word(cmt_pkg::OP_TICK, 2'd0, cmt_pkg::REG_CONTROL, 16'h0000);
      queue_word(cmt_pkg::OP_READ, 2'd0, cmt_pkg::REG_COUNTER, 16'h0000);
      queue_word(cmt_pkg::OP_WRITE, 2'd0, cmt_pkg::REG_START, 16'h0000);
      queue_word(cmt_pkg::OP_READ, 2'd0, cmt_pkg::REG_START, 16'h0000);

      total = pending_words.size() + RANDOM_WORDS;
      while (pending_words.size() < total) begin
         r = $urandom_range(0, 19);
         ch = $urandom_range(0, 3);
         if (r < 9) begin
            repeat ($urandom_range(1, 24))
               queue_word(cmt_pkg::OP_TICK, 2'($urandom),
                          cmt_pkg::reg_type'(2'($urandom)), 16'($urandom));
         end else if (r < 12) begin
            queue_word(cmt_pkg::OP_READ, 2'(ch), cmt_pkg::reg_type'(2'($urandom)),
                       16'($urandom));
         end else if (r < 17) begin
            case (cmt_pkg::reg_type'(2'($urandom_range(0, 3))))
               cmt_pkg::REG_CONTROL:
                  queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_CONTROL,
                             ($urandom_range(0, 9) == 0) ?
                             16'($urandom) : {9'd0, 1'($urandom), 4'd0, 2'($urandom)});
               cmt_pkg::REG_COMPARE:
                  queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_COMPARE,
                             small_or_wide());
               cmt_pkg::REG_COUNTER:
                  queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_COUNTER,
                             small_or_wide());
               default:
                  queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_START,
                             16'($urandom));
            endcase
         end else if (r < 19) begin
            // arm one channel for a quick match
            queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_CONTROL,
                       {9'd0, 1'b1, 4'd0, ($urandom_range(0, 3) == 0) ? 2'd1 : 2'd0});
            queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_COMPARE,
                       16'($urandom_range(0, 3)));
            queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_COUNTER, 16'd0);
            queue_word(cmt_pkg::OP_WRITE, 2'(ch), cmt_pkg::REG_START,
                       16'($urandom) | (16'd1 << (ch & 1)));
         end else begin
            queue_word(OP_UNUSED, 2'($urandom), cmt_pkg::reg_type'(2'($urandom)),
                       16'($urandom));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && due_results.size() == 0);
      repeat (10) @(posedge clock);
      $display("covered %0d ticks, %0d register reads and %0d register writes",
               n_ticks, n_reads, n_writes);
      $display("%0d result words carried a compare match interrupt", n_irq_words);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
src/cmt_pkg.sv
src/cmt_channel.sv
src/compare_match_timer_core.sv
tb/testbench.sv
